/* rtl/core/nce_pkg.sv */
`default_nettype none

package nce_pkg;

    // Odometer dimensions
    localparam int NUM_DIMS  = 4;
    localparam int COORD_W   = 16;
    localparam int ROW_W     = 32;
    localparam int RANK_W    = 3;
    localparam int ETYPE_W   = 3;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_TYPE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TENSOR_RANK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_DIM0    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_DIM1    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_DIM2    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_DIM3    = 3'd5;

    // Element type codes
    localparam logic [ETYPE_W-1:0] ET_INT8    = 3'd0;
    localparam logic [ETYPE_W-1:0] ET_UINT8   = 3'd1;
    localparam logic [ETYPE_W-1:0] ET_INT16   = 3'd2;
    localparam logic [ETYPE_W-1:0] ET_INT32   = 3'd3;
    localparam logic [ETYPE_W-1:0] ET_INT64   = 3'd4;
    localparam logic [ETYPE_W-1:0] ET_FLOAT32 = 3'd5;
    localparam logic [ETYPE_W-1:0] ET_FLOAT64 = 3'd6;

    typedef struct packed {
        logic [63:0] element_bits;
        logic        start_flag;
    } t_in_item;

    typedef struct packed {
        logic [COORD_W-1:0] coord0;
        logic [COORD_W-1:0] coord1;
        logic [COORD_W-1:0] coord2;
        logic [COORD_W-1:0] coord3;
        logic [ROW_W-1:0]   row_number;
    } t_out_item;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Nonzero test per element type; floats ignore the sign bit
    function automatic logic f_is_nonzero(input logic [ETYPE_W-1:0] etype,
                                          input logic [63:0] bits);
        logic r;
        begin
            unique case (etype)
                ET_INT8, ET_UINT8: r = (bits[7:0] != 8'd0);
                ET_INT16:          r = (bits[15:0] != 16'd0);
                ET_INT64:          r = (bits != 64'd0);
                ET_FLOAT32:        r = (bits[30:0] != 31'd0);
                ET_FLOAT64:        r = (bits[62:0] != 63'd0);
                default:           r = (bits[31:0] != 32'd0);
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/core/nce_front.sv */
`default_nettype none

module nce_front import nce_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_in_valid,
    input  wire t_in_item              i_in_data,
    output logic                       o_in_stall,
    input  wire t_q_status             i_q_stat,
    output logic                       o_push,
    output t_out_item                  o_push_data
);

    logic [ETYPE_W-1:0] r_etype;
    logic [RANK_W-1:0]  r_rank;
    logic [COORD_W-1:0] r_size [NUM_DIMS];
    logic [COORD_W-1:0] r_pos  [NUM_DIMS];
    logic [COORD_W-1:0] n_pos  [NUM_DIMS];
    logic [COORD_W-1:0] base_pos [NUM_DIMS];
    logic [COORD_W-1:0] out_pos  [NUM_DIMS];
    logic [ROW_W-1:0]   r_rows;
    logic [ROW_W-1:0]   n_rows;
    logic [ROW_W-1:0]   base_rows;
    logic [RANK_W-1:0]  rank_eff;
    logic               accept;
    logic               hit;

    assign o_in_stall = i_q_stat.full;
    assign accept     = i_in_valid && !i_q_stat.full;
    assign hit        = f_is_nonzero(r_etype, i_in_data.element_bits);

    // Clamp rank into 1..NUM_DIMS
    always_comb begin
        if (r_rank == '0) begin
            rank_eff = RANK_W'(1);
        end else if (r_rank > RANK_W'(NUM_DIMS)) begin
            rank_eff = RANK_W'(NUM_DIMS);
        end else begin
            rank_eff = r_rank;
        end
    end

    // Start flag clears coordinates and row count before use
    always_comb begin
        for (int d = 0; d < NUM_DIMS; d++) begin
            base_pos[d] = i_in_data.start_flag ? '0 : r_pos[d];
            out_pos[d]  = (RANK_W'(d) < rank_eff) ? base_pos[d] : '0;
        end
        base_rows = i_in_data.start_flag ? '0 : r_rows;
    end

    // Odometer advance, innermost active dimension first
    always_comb begin
        logic              carry;
        logic [COORD_W:0]  inc_val;
        carry   = 1'b1;
        inc_val = '0;
        for (int d = NUM_DIMS - 1; d >= 0; d--) begin
            n_pos[d] = base_pos[d];
            if ((RANK_W'(d) < rank_eff) && carry) begin
                inc_val = {1'b0, base_pos[d]} + (COORD_W+1)'(1);
                if (inc_val >= {1'b0, r_size[d]}) begin
                    n_pos[d] = '0;
                end else begin
                    n_pos[d] = inc_val[COORD_W-1:0];
                    carry    = 1'b0;
                end
            end
        end
    end

    // Saturating row count
    always_comb begin
        n_rows = base_rows;
        if (hit && (base_rows != '1)) begin
            n_rows = base_rows + ROW_W'(1);
        end
    end

    // Result toward the queue
    assign o_push = accept && hit;

    always_comb begin
        o_push_data.coord0     = out_pos[0];
        o_push_data.coord1     = out_pos[1];
        o_push_data.coord2     = out_pos[2];
        o_push_data.coord3     = out_pos[3];
        o_push_data.row_number = base_rows;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_etype <= ET_INT8;
            r_rank  <= RANK_W'(1);
            for (int d = 0; d < NUM_DIMS; d++) begin
                r_size[d] <= COORD_W'(1);
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ELEMENT_TYPE: r_etype   <= i_cfg_wdata[ETYPE_W-1:0];
                CFG_TENSOR_RANK:  r_rank    <= i_cfg_wdata[RANK_W-1:0];
                CFG_SIZE_DIM0:    r_size[0] <= i_cfg_wdata[COORD_W-1:0];
                CFG_SIZE_DIM1:    r_size[1] <= i_cfg_wdata[COORD_W-1:0];
                CFG_SIZE_DIM2:    r_size[2] <= i_cfg_wdata[COORD_W-1:0];
                CFG_SIZE_DIM3:    r_size[3] <= i_cfg_wdata[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // Odometer and row count state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= '0;
            for (int d = 0; d < NUM_DIMS; d++) begin
                r_pos[d] <= '0;
            end
        end else if (accept) begin
            r_rows <= n_rows;
            for (int d = 0; d < NUM_DIMS; d++) begin
                r_pos[d] <= n_pos[d];
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/nce_queue.sv */
`default_nettype none

module nce_queue import nce_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_out_item i_push_data,
    input  wire logic      i_pop,
    output t_out_item      o_head,
    output t_q_status      o_stat
);

    t_out_item             r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_AW:0]     r_count;
    logic                  do_push;
    logic                  do_pop;

    always_comb begin
        o_stat.full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
        o_stat.empty = (r_count == '0);
    end

    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (QUEUE_AW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (QUEUE_AW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/nce_back.sv */
`default_nettype none

module nce_back import nce_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_q_status i_q_stat,
    input  wire t_out_item i_head,
    output logic           o_pop,
    output logic           o_out_valid,
    output t_out_item      o_out_data,
    input  wire logic      i_out_stall
);

    logic      r_valid;
    t_out_item r_data;

    // Refill the output register when it is empty or being taken
    assign o_pop       = !i_q_stat.empty && (!r_valid || !i_out_stall);
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_head;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/nonzero_coordinate_emitter.sv */
// Nonzero coordinate emitter (argwhere).
// Input channel: one condition element per request (raw bits plus a start
// flag), valid/stall handshake. Elements arrive in row-major order; the
// block keeps an odometer over the configured rank and dimension sizes.
// Output channel: one request per nonzero element carrying its coordinates
// (unused dimensions read zero) and a saturating row number. Zero elements
// produce nothing.
// Configuration: write enable, register index and 16-bit data; it is to be
// written only while the block is idle, which the block does not enforce.
// Throughput: one element per cycle while the queue is not full. A result
// accepted at an edge is written into the queue, then moves into the output
// register once it is empty or being taken. The odometer and nonzero test
// run in the accept cycle. A four-entry queue sits between the front and the
// output register; the input stalls only while that queue is full.
// Reset (synchronous, active low) clears the odometer, row count and queue
// and loads the configuration defaults: int8, rank 1, all sizes 1.
// While the receiver stalls, the output request holds and the queue fills.
`default_nettype none

module nonzero_coordinate_emitter import nce_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_in_valid,
    input  wire t_in_item              i_in_data,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    output t_out_item                  o_out_data,
    input  wire logic                  i_out_stall
);

    t_q_status q_stat;
    t_out_item push_data;
    t_out_item head;
    logic      push;
    logic      pop;

    nce_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_push_data (push_data)
    );

    nce_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_stat      (q_stat)
    );

    nce_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    // Queue cannot be full and empty at once
    a_q_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty");

    // Front never writes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full)
        else $error("push into full queue");

    // A pending entry reaches an empty output register in the next cycle
    a_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!q_stat.empty && !o_out_valid) |=> o_out_valid)
        else $error("output register not refilled");

endmodule

`default_nettype wire
